>>> design/stt_pkg.sv
// Package: shared types, codes and character tests for the source text tokenizer.
package stt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_SLASH = 4'd1,
    MODE_WORD  = 4'd2,
    MODE_INT   = 4'd3,
    MODE_FRAC  = 4'd4,
    MODE_STR   = 4'd5,
    MODE_ESC   = 4'd6,
    MODE_LINE  = 4'd7,
    MODE_BLOCK = 4'd8,
    MODE_BSTAR = 4'd9
  } scan_mode_t;

  localparam logic [3:0] CLS_WORD    = 4'd0;
  localparam logic [3:0] CLS_NUM     = 4'd1;
  localparam logic [3:0] CLS_STR     = 4'd2;
  localparam logic [3:0] CLS_LPAREN  = 4'd3;
  localparam logic [3:0] CLS_RPAREN  = 4'd4;
  localparam logic [3:0] CLS_LBRACE  = 4'd5;
  localparam logic [3:0] CLS_RBRACE  = 4'd6;
  localparam logic [3:0] CLS_LBRACK  = 4'd7;
  localparam logic [3:0] CLS_RBRACK  = 4'd8;
  localparam logic [3:0] CLS_COMMA   = 4'd9;
  localparam logic [3:0] CLS_SEMI    = 4'd10;
  localparam logic [3:0] CLS_ILLEGAL = 4'd11;
  localparam logic [3:0] CLS_EOF     = 4'd12;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // one result item
  typedef struct packed {
    logic [3:0] token_class;
    logic [7:0] token_byte;
    logic       has_byte;
    logic       first_of_token;
    logic       last_of_token;
  } tok_res_t;

  // results of one step: count (0..2) and the slots in order
  typedef struct packed {
    logic [1:0] cnt;
    tok_res_t   r0;
    tok_res_t   r1;
  } stt_step_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == CH_STAR || c == CH_SLASH || c == 8'h25 ||
           c == 8'h5E || c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E ||
           c == 8'h26 || c == 8'h7C;
  endfunction

  function automatic tok_res_t mk_res(input logic [3:0] cls, input logic [7:0] b,
                                      input logic has, input logic first,
                                      input logic last);
    tok_res_t r;
    r.token_class    = cls;
    r.token_byte     = b;
    r.has_byte       = has;
    r.first_of_token = first;
    r.last_of_token  = last;
    return r;
  endfunction

endpackage

>>> design/stt_if.sv
// Interfaces: text input channel and token output channel.
interface stt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface stt_token_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_class;
  logic [7:0] token_byte;
  logic       has_byte;
  logic       first_of_token;
  logic       last_of_token;
  modport source (output valid, token_class, token_byte, has_byte, first_of_token,
                  last_of_token, input ready);
  modport sink (input valid, token_class, token_byte, has_byte, first_of_token,
                last_of_token, output ready);
endinterface

>>> design/source_text_tokenizer_top.sv
// Top level of the source text tokenizer: scanner core and result queue.
//
//   channel    dir  payload                                         transfer when
//   text_in    in   text_byte[7:0], end_of_text                     valid && ready
//   token_out  out  token_class[3:0], token_byte[7:0], has_byte,    valid && ready
//                   first_of_token, last_of_token
//
// One byte is taken per cycle while ready is high; the step logic turns it into zero,
// one or two results in the same cycle and writes them into a four-entry result
// queue. The output side sends one result a cycle while token_out.ready is high,
// so bytes that yield two results (token close plus new one-byte token, or flush
// plus eof) go out in turn. text_in.ready is high while the queue has room for two
// results, so input is taken while earlier results still wait; a stalled output
// fills the queue and holds input off. Reset is synchronous; no clearing pass.
module source_text_tokenizer_top
  import stt_pkg::*;
(
  input logic         clk,
  input logic         rst,
  stt_text_if.sink    text_in,
  stt_token_if.source token_out
);

  stt_step_t step_res;
  tok_res_t  head_res;
  logic      room;
  logic      step;

  // a byte transfer both updates the scan state and pushes its results
  assign text_in.ready = room;
  assign step          = text_in.valid && room;

  stt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (text_in.text_byte),
    .end_of_text (text_in.end_of_text),
    .res         (step_res)
  );

  stt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_res  (step_res),
    .room      (room),
    .out_valid (token_out.valid),
    .out_ready (token_out.ready),
    .out_res   (head_res)
  );

  assign token_out.token_class    = head_res.token_class;
  assign token_out.token_byte     = head_res.token_byte;
  assign token_out.has_byte       = head_res.has_byte;
  assign token_out.first_of_token = head_res.first_of_token;
  assign token_out.last_of_token  = head_res.last_of_token;

endmodule

>>> design/stt_core.sv
// Scanner core: scan state registers and the per-byte step logic.
module stt_core
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output stt_step_t  res
);

  scan_mode_t scan_mode, scan_mode_next;
  logic [7:0] held_char, held_char_next;
  logic [3:0] held_kind, held_kind_next;
  logic       held_is_first, held_is_first_next;
  logic       held_present, held_present_next;
  logic       string_awaits_first, string_awaits_first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode           <= MODE_IDLE;
      held_char           <= '0;
      held_kind           <= '0;
      held_is_first       <= 1'b0;
      held_present        <= 1'b0;
      string_awaits_first <= 1'b0;
    end else if (step) begin
      scan_mode           <= scan_mode_next;
      held_char           <= held_char_next;
      held_kind           <= held_kind_next;
      held_is_first       <= held_is_first_next;
      held_present        <= held_present_next;
      string_awaits_first <= string_awaits_first_next;
    end
  end

  logic       word_char;
  logic       do_eoc, ext;
  scan_mode_t ext_mode;
  logic       do_strchar, do_begin;
  logic [3:0] single_cls;
  logic       is_single;
  tok_res_t   slot0, slot1, nr;
  logic [1:0] n;
  logic       emit_now;

  assign word_char = is_alpha(text_byte) || is_num(text_byte) || is_op(text_byte);

  always_comb begin
    is_single  = 1'b1;
    single_cls = CLS_ILLEGAL;
    case (text_byte)
      CH_LPAREN: single_cls = CLS_LPAREN;
      CH_RPAREN: single_cls = CLS_RPAREN;
      CH_LBRACE: single_cls = CLS_LBRACE;
      CH_RBRACE: single_cls = CLS_RBRACE;
      CH_LBRACK: single_cls = CLS_LBRACK;
      CH_RBRACK: single_cls = CLS_RBRACK;
      CH_COMMA:  single_cls = CLS_COMMA;
      CH_SEMI:   single_cls = CLS_SEMI;
      default:   is_single = 1'b0;
    endcase
  end

  // Results go into slot0 then slot1; each stage below emits at most once.
  always_comb begin
    scan_mode_next           = scan_mode;
    held_char_next           = held_char;
    held_kind_next           = held_kind;
    held_is_first_next       = held_is_first;
    held_present_next        = held_present;
    string_awaits_first_next = string_awaits_first;
    slot0      = '0;
    slot1      = '0;
    n          = 2'd0;
    do_eoc     = 1'b0;
    ext        = 1'b0;
    ext_mode   = MODE_WORD;
    do_strchar = 1'b0;
    do_begin   = 1'b0;
    nr         = '0;
    emit_now   = 1'b0;

    if (end_of_text || text_byte == CH_NUL) begin
      if (held_present) begin
        slot0 = mk_res(held_kind, held_char, 1'b1, held_is_first, 1'b1);
        n     = 2'd1;
      end else if ((scan_mode == MODE_STR || scan_mode == MODE_ESC) &&
                   string_awaits_first) begin
        slot0 = mk_res(CLS_STR, CH_NUL, 1'b0, 1'b1, 1'b1);
        n     = 2'd1;
      end
      if (n == 2'd0) slot0 = mk_res(CLS_EOF, CH_NUL, 1'b0, 1'b1, 1'b1);
      else           slot1 = mk_res(CLS_EOF, CH_NUL, 1'b0, 1'b1, 1'b1);
      n = n + 2'd1;
      scan_mode_next           = MODE_IDLE;
      held_char_next           = '0;
      held_kind_next           = '0;
      held_is_first_next       = 1'b0;
      held_present_next        = 1'b0;
      string_awaits_first_next = 1'b0;
    end else begin
      case (scan_mode)
        MODE_SLASH: begin
          if (text_byte == CH_SLASH) begin
            held_present_next = 1'b0;
            scan_mode_next    = MODE_LINE;
          end else if (text_byte == CH_STAR) begin
            held_present_next = 1'b0;
            scan_mode_next    = MODE_BLOCK;
          end else begin
            do_eoc = 1'b1;
            ext    = word_char;
          end
        end
        MODE_WORD: begin
          do_eoc = 1'b1;
          ext    = word_char;
        end
        MODE_INT: begin
          do_eoc = 1'b1;
          if (text_byte == CH_POINT) begin
            ext      = 1'b1;
            ext_mode = MODE_FRAC;
          end else begin
            ext      = is_num(text_byte);
            ext_mode = MODE_INT;
          end
        end
        MODE_FRAC: begin
          do_eoc   = 1'b1;
          ext      = is_num(text_byte);
          ext_mode = MODE_FRAC;
        end
        MODE_STR: begin
          if (text_byte == CH_QUOTE) begin
            if (held_present) begin
              slot0 = mk_res(held_kind, held_char, 1'b1, held_is_first, 1'b1);
              n     = 2'd1;
              held_present_next = 1'b0;
            end else if (string_awaits_first) begin
              slot0 = mk_res(CLS_STR, CH_NUL, 1'b0, 1'b1, 1'b1);
              n     = 2'd1;
            end
            string_awaits_first_next = 1'b0;
            scan_mode_next           = MODE_IDLE;
          end else begin
            do_strchar = 1'b1;
            if (text_byte == CH_BSLASH) scan_mode_next = MODE_ESC;
          end
        end
        MODE_ESC: begin
          do_strchar     = 1'b1;
          scan_mode_next = MODE_STR;
        end
        MODE_LINE: begin
          if (text_byte == CH_LF) scan_mode_next = MODE_IDLE;
        end
        MODE_BLOCK: begin
          if (text_byte == CH_STAR) scan_mode_next = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          if (text_byte == CH_SLASH) scan_mode_next = MODE_IDLE;
          else if (text_byte != CH_STAR) scan_mode_next = MODE_BLOCK;
        end
        default: begin
          held_present_next = 1'b0;
          do_begin          = 1'b1;
        end
      endcase

      // extend the held token, or close it and restart on this byte
      if (do_eoc) begin
        if (held_present) begin
          slot0 = mk_res(held_kind, held_char, 1'b1, held_is_first, !ext);
          n     = 2'd1;
        end
        if (ext) begin
          held_char_next     = text_byte;
          held_is_first_next = 1'b0;
          held_present_next  = 1'b1;
          scan_mode_next     = ext_mode;
        end else begin
          held_present_next = 1'b0;
          do_begin          = 1'b1;
        end
      end

      if (do_strchar) begin
        if (held_present) begin
          slot0 = mk_res(held_kind, held_char, 1'b1, held_is_first, 1'b0);
          n     = 2'd1;
        end
        held_char_next           = text_byte;
        held_kind_next           = CLS_STR;
        held_is_first_next       = string_awaits_first;
        held_present_next        = 1'b1;
        string_awaits_first_next = 1'b0;
      end

      // start of a new token on this byte
      if (do_begin) begin
        scan_mode_next = MODE_IDLE;
        if (text_byte == CH_SPACE || text_byte == CH_TAB || text_byte == CH_LF ||
            text_byte == CH_CR) begin
          scan_mode_next = MODE_IDLE;
        end else if (is_single) begin
          nr       = mk_res(single_cls, text_byte, 1'b1, 1'b1, 1'b1);
          emit_now = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          scan_mode_next           = MODE_STR;
          string_awaits_first_next = 1'b1;
        end else if (text_byte == CH_SLASH) begin
          scan_mode_next     = MODE_SLASH;
          held_char_next     = text_byte;
          held_kind_next     = CLS_WORD;
          held_is_first_next = 1'b1;
          held_present_next  = 1'b1;
        end else if (is_alpha(text_byte) || is_op(text_byte)) begin
          scan_mode_next     = MODE_WORD;
          held_char_next     = text_byte;
          held_kind_next     = CLS_WORD;
          held_is_first_next = 1'b1;
          held_present_next  = 1'b1;
        end else if (is_num(text_byte)) begin
          scan_mode_next     = MODE_INT;
          held_char_next     = text_byte;
          held_kind_next     = CLS_NUM;
          held_is_first_next = 1'b1;
          held_present_next  = 1'b1;
        end else begin
          nr       = mk_res(CLS_ILLEGAL, text_byte, 1'b1, 1'b1, 1'b1);
          emit_now = 1'b1;
        end
        if (emit_now) begin
          if (n == 2'd0) slot0 = nr;
          else           slot1 = nr;
          n = n + 2'd1;
        end
      end
    end

    res.cnt = n;
    res.r0  = slot0;
    res.r1  = slot1;
  end

endmodule

>>> design/stt_outq.sv
// Result queue: four entries, takes up to two results a cycle while it has room, sends one while out_ready is high.
module stt_outq
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  stt_step_t push_res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_res_t  out_res
);

  tok_res_t   mem [4];
  logic [1:0] head, tail;
  logic [2:0] count;
  logic [1:0] push_cnt;
  logic       pop;

  assign push_cnt  = push ? push_res.cnt : 2'd0;
  assign room      = count <= 3'd2;
  assign out_valid = count != 3'd0;
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + {1'b0, pop};
      tail  <= tail + push_cnt;
      count <= count + {1'b0, push_cnt} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[tail] <= push_res.r0;
    if (push_cnt == 2'd2) mem[tail + 2'd1] <= push_res.r1;
  end

endmodule
